FILE: rtl/core/gchc_pkg.sv
package gchc_pkg;

  localparam int GearEntries   = 256;
  localparam int MaxChunkLimit = 131072;
  localparam int LenW          = 18;

  localparam logic [1:0] ReasonStrict = 2'd0;
  localparam logic [1:0] ReasonLoose  = 2'd1;
  localparam logic [1:0] ReasonMax    = 2'd2;
  localparam logic [1:0] ReasonEnd    = 2'd3;

  localparam logic [2:0] RegMinSize   = 3'd0;
  localparam logic [2:0] RegAvgSize   = 3'd1;
  localparam logic [2:0] RegMaxSize   = 3'd2;
  localparam logic [2:0] RegMaskSmall = 3'd3;
  localparam logic [2:0] RegMaskLarge = 3'd4;

  localparam logic [63:0] MaskSmallReset = 64'h0000d90303530000;
  localparam logic [63:0] MaskLargeReset = 64'h0000590103530000;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    rotl32 = (x << s) | (x >> (32 - s));
  endfunction

  function automatic void md5_block(inout logic [31:0] h [4], input logic [31:0] w [16]);
    logic [31:0] a, b, c, d, f, t;
    int g, r;
    int rr [16];
    logic [31:0] k [64];
    rr = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    a = h[0]; b = h[1]; c = h[2]; d = h[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) & 15;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) & 15;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) & 15;
      end
      f = f + a + k[i] + w[g];
      r = rr[((i >> 4) << 2) | (i & 3)];
      t = d; d = c; c = b;
      b = b + rotl32(f, r);
      a = t;
    end
    h[0] = h[0] + a; h[1] = h[1] + b; h[2] = h[2] + c; h[3] = h[3] + d;
  endfunction

  // Gear constant for one byte value: low 64 bits of the MD5 of 64 equal bytes.
  // Evaluated only on constant indexes, so it folds to a table at elaboration.
  function automatic logic [63:0] gear_entry(input logic [7:0] sym);
    logic [31:0] h [4];
    logic [31:0] w [16];
    h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    for (int j = 0; j < 16; j++) w[j] = {sym, sym, sym, sym};
    md5_block(h, w);
    for (int j = 0; j < 16; j++) w[j] = '0;
    w[0] = 32'h80;
    w[14] = 32'd512;
    md5_block(h, w);
    gear_entry = {h[1], h[0]};
  endfunction

  typedef struct packed {
    logic        tail;
    logic        by_max;
    logic [LenW-1:0] limit;
  } chunk_ctl_t;

endpackage

FILE: rtl/core/gchc_gear_rom.sv
module gchc_gear_rom import gchc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  addr,
  output logic [63:0] data
);

  logic [63:0] mem [GearEntries];

  for (genvar i = 0; i < GearEntries; i++) begin : g_init
    assign mem[i] = gear_entry(8'(i));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= mem[addr];
    end
  end

endmodule

FILE: rtl/core/gear_hash_content_defined_chunker_core.sv
// Content-defined chunker with a normalized gear fingerprint.
// Input stream: s_tvalid/s_tready/s_tdata, one data byte per beat with the
// count of bytes left in the data (including this byte). Output stream:
// m_tvalid/m_tready/m_tdata, one beat per closed chunk carrying its length
// and the reason for the cut. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_wdata) and must be written while the block is idle.
// Throughput is one byte per cycle when not stalled (see below). A byte
// enters stage one, where the gear table (a 256-entry synchronous ROM) is
// read; in stage two the fingerprint is shifted and added, the mask and
// limit are tested, and any result goes into the output register.
// The fingerprint and chunk position live in stage two, so each byte sees
// the state left by the previous byte without any forwarding path.
// When the receiver stalls, the output register holds the result and the
// pipeline stops accepting only while the byte in stage two would produce
// a new result with the output register still occupied. Reset restores
// register defaults and clears the fingerprint and position.
module gear_hash_content_defined_chunker_core import gchc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] bytes_left
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [17:0] chunk_length, [19:18] cut_reason, rest zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [17:0] min_size, max_size;
  logic [16:0] avg_size;
  logic [63:0] mask_small, mask_large;

  // Stage one holds the byte's chunk control while the ROM is read.
  logic        v1;
  chunk_ctl_t  ctl1;
  // Chunk state after the last byte that left stage two.
  logic [63:0] fingerprint;
  logic [LenW-1:0] chunk_position;
  logic [LenW-1:0] chunk_limit;
  logic        tail_mode, limit_by_max;

  logic [63:0] gear;
  logic        advance;
  logic        out_full;

  gchc_gear_rom u_rom (
    .clk (clk),
    .en  (advance),
    .addr(s_tdata[7:0]),
    .data(gear)
  );

  // Stage one control: a new chunk starts when the previous byte closed
  // the chunk. That is only known in stage two, so stage one carries the
  // raw bytes_left derived limit and stage two selects between it and the
  // running chunk.
  logic [31:0] left;
  logic [17:0] maxc;
  logic        tail_new, bymax_new;
  logic [LenW-1:0] limit_new;

  always_comb begin
    left = (s_tdata[39:8] == 32'd0) ? 32'd1 : s_tdata[39:8];
    if (max_size == 18'd0) begin
      maxc = 18'd1;
    end else if (max_size > LenW'(MaxChunkLimit)) begin
      maxc = LenW'(MaxChunkLimit);
    end else begin
      maxc = max_size;
    end
    bymax_new = 1'b0;
    if ({14'd0, min_size} >= left) begin
      tail_new  = 1'b1;
      limit_new = (left > 32'(MaxChunkLimit)) ? LenW'(MaxChunkLimit) : left[LenW-1:0];
    end else begin
      tail_new = 1'b0;
      if (left > {14'd0, maxc}) begin
        limit_new = maxc;
        bymax_new = 1'b1;
      end else begin
        limit_new = left[LenW-1:0];
      end
    end
  end

  // Stage two.
  logic        first2;
  logic        tail2, bymax2;
  logic [LenW-1:0] pos2, lim2, next2;
  logic [63:0] fp_prev, fp_new;
  logic        strict, mask_hit, limit_hit, fire;
  logic [1:0]  reason;

  always_comb begin
    first2  = (chunk_position == '0);
    tail2   = first2 ? ctl1.tail   : tail_mode;
    bymax2  = first2 ? ctl1.by_max : limit_by_max;
    lim2    = first2 ? ctl1.limit  : chunk_limit;
    pos2    = chunk_position;
    next2   = pos2 + LenW'(1);
    fp_prev = first2 ? 64'd0 : fingerprint;
    fp_new  = (fp_prev << 1) + gear;
    strict  = {1'b0, pos2} < {2'b0, avg_size};
    mask_hit  = !tail2 && ((fp_new & (strict ? mask_small : mask_large)) == 64'd0);
    limit_hit = next2 >= lim2;
    fire    = v1 && (mask_hit || limit_hit);
    if (mask_hit) begin
      reason = strict ? ReasonStrict : ReasonLoose;
    end else if (!tail2 && bymax2) begin
      reason = ReasonMax;
    end else begin
      reason = ReasonEnd;
    end
  end

  // The pipeline only waits when stage two has a result and nowhere to put it.
  assign out_full = m_tvalid && !m_tready;
  assign advance  = !(out_full && fire);
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_size   <= 18'd512;
      avg_size   <= 17'd4096;
      max_size   <= 18'd8192;
      mask_small <= MaskSmallReset;
      mask_large <= MaskLargeReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegMinSize:   min_size   <= cfg_wdata[17:0];
        RegAvgSize:   avg_size   <= cfg_wdata[16:0];
        RegMaxSize:   max_size   <= cfg_wdata[17:0];
        RegMaskSmall: mask_small <= cfg_wdata;
        RegMaskLarge: mask_large <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1             <= 1'b0;
      m_tvalid       <= 1'b0;
      chunk_position <= '0;
      fingerprint    <= '0;
      chunk_limit    <= '0;
      tail_mode      <= 1'b0;
      limit_by_max   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (advance) begin
        v1 <= s_tvalid;
        ctl1.tail   <= tail_new;
        ctl1.by_max <= bymax_new;
        ctl1.limit  <= limit_new;
        if (v1) begin
          tail_mode    <= tail2;
          limit_by_max <= bymax2;
          chunk_limit  <= lim2;
          fingerprint  <= fp_new;
          chunk_position <= fire ? '0 : next2;
        end
        if (fire) begin
          m_tvalid <= 1'b1;
          m_tdata  <= {4'd0, reason, next2};
        end
      end
    end
  end

  // The limit latched for a running chunk never exceeds the chunk cap.
  a_limit_cap: assert property (@(posedge clk) disable iff (rst)
    chunk_position != '0 |-> chunk_limit <= LenW'(MaxChunkLimit))
    else $error("chunk limit above cap");

  // A result is never produced with a zero length.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[17:0] != 18'd0)
    else $error("zero length");

  // A stalled result stays put until the receiver takes it.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_full |=> m_tvalid && $stable(m_tdata))
    else $error("result changed during stall");

  // The position stays below the limit between bytes of a chunk.
  a_pos_lim: assert property (@(posedge clk) disable iff (rst)
    chunk_position != '0 |-> chunk_position < chunk_limit)
    else $error("position past limit");

endmodule

FILE: verif/gear_hash_content_defined_chunker_core_tb.sv
module gear_hash_content_defined_chunker_core_tb;
  import gchc_pkg::*;

  typedef struct packed {
    logic [LenW-1:0] length;
    logic [1:0]      reason;
  } chunk_cut_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;     // [7:0] data_byte, [39:8] bytes_left
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [17:0] chunk_length, [19:18] cut_reason
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  gear_hash_content_defined_chunker_core dut (.*);

  always #5 clk = ~clk;

  // Predicted chunk boundaries, oldest first.
  chunk_cut_t cut_q[$];
  int mismatches = 0;

  // Predictor copy of the configuration registers.
  logic [17:0] min_r;
  logic [16:0] avg_r;
  logic [17:0] max_r;
  logic [63:0] mask_s, mask_l;

  // Predictor copy of the chunking state.
  logic [63:0] fp;
  logic [17:0] pos, lim;
  logic        tail, by_max;
  logic [63:0] gear [256];

  // MD5 scratch used only to build the gear constants.
  logic [31:0] md5_k [64];
  logic [31:0] md5_h [4];
  logic [31:0] md5_w [16];

  // One MD5 compression of md5_w into md5_h. The round constants are the
  // integer parts of |sin(i+1)| * 2^32, built once before the table.
  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int g, s;
    int shifts [16];
    shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = md5_h[0]; b = md5_h[1]; c = md5_h[2]; d = md5_h[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      f = f + a + md5_k[i] + md5_w[g];
      s = shifts[(i / 16) * 4 + i % 4];
      t = d; d = c; c = b;
      b = b + ((f << s) | (f >> (32 - s)));
      a = t;
    end
    md5_h[0] += a; md5_h[1] += b; md5_h[2] += c; md5_h[3] += d;
  endtask

  task automatic build_gear_table();
    real r;
    for (int i = 0; i < 64; i++) begin
      r = $sin(i + 1);
      if (r < 0.0) r = -r;
      md5_k[i] = 32'(longint'($floor(r * 4294967296.0)));
    end
    for (int v = 0; v < 256; v++) begin
      md5_h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
      for (int j = 0; j < 16; j++) md5_w[j] = {4{v[7:0]}};
      md5_compress();
      for (int j = 0; j < 16; j++) md5_w[j] = '0;
      md5_w[0] = 32'h80;
      md5_w[14] = 32'd512;
      md5_compress();
      gear[v] = {md5_h[1], md5_h[0]};
    end
  endtask

  // Append one predicted cut at the back of the queue.
  task automatic queue_cut(input logic [17:0] len, input logic [1:0] why);
    chunk_cut_t c;
    c.length = len;
    c.reason = why;
    cut_q = {cut_q, c};
  endtask

  // Advance the chunking state by one accepted byte and queue any cut.
  task automatic chunk_byte(input logic [7:0] b, input logic [31:0] left);
    logic [32:0] rem;
    logic [17:0] maxc, nxt;
    logic        strict, cut;
    cut = 1'b0;
    if (pos == 0) begin
      // The limit is latched at the first byte of each chunk.
      maxc = (max_r == 0) ? 18'd1 : (max_r > MaxChunkLimit) ? 18'(MaxChunkLimit) : max_r;
      rem = (left == 0) ? 33'd1 : {1'b0, left};
      fp = '0;
      by_max = 1'b0;
      if (rem <= min_r) begin
        tail = 1'b1;
        lim = (rem > MaxChunkLimit) ? 18'(MaxChunkLimit) : rem[17:0];
      end else begin
        tail = 1'b0;
        if (rem > maxc) begin
          lim = maxc;
          by_max = 1'b1;
        end else begin
          lim = rem[17:0];
        end
      end
    end
    nxt = pos + 18'd1;
    if (!tail) begin
      // Strict mask below the average size, loose mask from there on.
      strict = ({1'b0, pos} < {2'b0, avg_r});
      fp = (fp << 1) + gear[b];
      if ((fp & (strict ? mask_s : mask_l)) == 0) begin
        queue_cut(nxt, strict ? ReasonStrict : ReasonLoose);
        cut = 1'b1;
      end
    end
    if (!cut && nxt >= lim) begin
      queue_cut(nxt, (!tail && by_max) ? ReasonMax : ReasonEnd);
      cut = 1'b1;
    end
    pos = cut ? 18'd0 : nxt;
  endtask

  // Result checker: every output beat is matched against the oldest cut.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (cut_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: length %0d reason %0d", m_tdata[17:0], m_tdata[19:18]);
      end else begin
        if (m_tdata[17:0] !== cut_q[0].length || m_tdata[19:18] !== cut_q[0].reason) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cut mismatch: expected length %0d reason %0d, got length %0d reason %0d",
                     cut_q[0].length, cut_q[0].reason, m_tdata[17:0], m_tdata[19:18]);
        end
        void'(cut_q.pop_front());
      end
    end
  end

  // Receiver: long hold-off on request, else always ready, random or patterned.
  int  rx_mode = 0;
  int  hold_req = 0;
  int  hold_left = 0;
  int  rx_phase = 0;
  always @(negedge clk) begin
    rx_phase++;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= (rx_phase % 7) < 4;
      endcase
    end
  end

  // Watchdog: too many cycles without a beat while work is outstanding.
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (!s_tvalid && cut_q.size() == 0)) begin
      quiet <= 0;
    end else if (quiet >= 5000) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Sender: bursts of random length, with random gaps between when gaps_on.
  bit gaps_on = 1'b0;
  int burst_left = 0;

  task automatic send_byte(input logic [7:0] b, input logic [31:0] left);
    if (burst_left == 0) begin
      if (gaps_on) begin
        repeat ($urandom_range(1, 6)) @(negedge clk) s_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {left, b};
    do @(posedge clk); while (!s_tready);
    chunk_byte(b, left);
  endtask

  // Stop offering bytes and let every predicted cut come out; the extra
  // cycles cover a byte still in the two-stage pipeline with no result.
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk) s_tvalid <= 1'b0;
    while (cut_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      RegMinSize:   min_r = val[17:0];
      RegAvgSize:   avg_r = val[16:0];
      RegMaxSize:   max_r = val[17:0];
      RegMaskSmall: mask_s = val;
      RegMaskLarge: mask_l = val;
      default: ;
    endcase
  endtask

  task automatic set_sizes(input logic [17:0] mn, input logic [16:0] av, input logic [17:0] mx,
                           input logic [63:0] ms, input logic [63:0] ml);
    write_reg(RegMinSize, 64'(mn));
    write_reg(RegAvgSize, 64'(av));
    write_reg(RegMaxSize, 64'(mx));
    write_reg(RegMaskSmall, ms);
    write_reg(RegMaskLarge, ml);
  endtask

  // A data set of n bytes with bytes_left counting down to one.
  task automatic send_data(input int n);
    for (int i = n; i >= 1; i--) send_byte(8'($urandom), 32'(i));
  endtask

  // Short directed cases with small sizes so that every cut kind shows up.
  task automatic test_directed();
    set_sizes(18'd4, 17'd3, 18'd8, '1, '1);
    send_byte(8'h00, 32'd0);           // zero bytes_left closes a one-byte chunk
    send_byte(8'hff, 32'd1);
    send_data(3);                      // short tail, not hashed
    send_data(10);                     // max-size cut, then end-of-data tail
    send_data(8);                      // remaining data equals max size: end of data
    write_reg(RegMaskSmall, '0);       // every byte cuts on the strict mask
    send_byte(8'h5a, 32'hffffffff);
    send_byte(8'ha5, 32'h80000000);
    write_reg(RegMaskSmall, '1);
    write_reg(RegMaskLarge, '0);       // loose cut once past the average
    send_data(9);
    write_reg(3'd5, '0);               // unknown register index is ignored
    write_reg(3'd7, '1);
  endtask

  // Extremes of the size registers with short data sets.
  task automatic test_long_chunks();
    set_sizes(18'd0, 17'd0, 18'd0, '1, '1);
    send_data(3);                      // max size zero acts as one
    set_sizes(18'h3ffff, 17'h1ffff, 18'h3ffff, '1, '1);
    send_data(20);                     // whole set is one tail
    write_reg(RegMinSize, 64'd0);
    send_data(20);                     // limited by the end of data
    send_data(1);
  endtask

  // Random data sets under several settings, including the register extremes.
  task automatic test_random();
    logic [63:0] ms, ml;
    int n;
    for (int ph = 0; ph < 8; ph++) begin
      ms = '0;
      ml = '0;
      repeat ($urandom_range(0, 3)) ms[$urandom_range(0, 9)] = 1'b1;
      repeat ($urandom_range(0, 2)) ml[$urandom_range(0, 9)] = 1'b1;
      if (ph == 6) begin
        ms = {$urandom, $urandom};
        ml = {$urandom, $urandom} & 64'h3f;
      end
      if (ph == 0)
        set_sizes(18'd0, 17'd0, 18'd1, ms, ml);
      else if (ph == 1)
        set_sizes(18'h3ffff, 17'h1ffff, 18'h3ffff, ms, ml);
      else
        set_sizes(18'($urandom_range(0, 20)), 17'($urandom_range(0, 70)),
                  18'($urandom_range(1, 40)), ms, ml);
      gaps_on = $urandom_range(0, 1);
      rx_mode = $urandom_range(0, 2);
      for (int k = 0; k < 35; ) begin
        if ($urandom_range(0, 5) == 0) begin
          send_byte(8'($urandom), $urandom);   // noise: any bytes_left
          k++;
        end else begin
          n = $urandom_range(1, 30);
          if (ph == 1) n = $urandom_range(1, 6);
          send_data(n);
          k += n;
        end
      end
    end
  endtask

  // The receiver holds off while the sender keeps offering bytes that all cut.
  task automatic test_backpressure();
    set_sizes(18'd0, 17'd4, 18'd6, '0, 64'h1);
    gaps_on = 1'b0;
    rx_mode = 1;
    hold_req = 300;
    send_data(40);
  endtask

  initial begin
    build_gear_table();
    min_r = 18'd512;
    avg_r = 17'd4096;
    max_r = 18'd8192;
    mask_s = MaskSmallReset;
    mask_l = MaskLargeReset;
    fp = '0; pos = '0; lim = '0; tail = 1'b0; by_max = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    send_data(20);                     // reset defaults: whole set is one tail
    test_directed();
    test_random();
    test_backpressure();
    rx_mode = 0;
    test_long_chunks();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && cut_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: gear_hash_content_defined_chunker_core.f
rtl/core/gchc_pkg.sv
rtl/core/gchc_gear_rom.sv
rtl/core/gear_hash_content_defined_chunker_core.sv
verif/gear_hash_content_defined_chunker_core_tb.sv
